// ----- hw/rtl/jhl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhl_pkg
// Shared types and constants of the jump history list.
// ----------------------------------------------------------------------------
package jhl_pkg;

    localparam int JHL_DEPTH = 64;

    localparam int KEY_W  = 16;
    localparam int ROW_W  = 24;
    localparam int COL_W  = 16;
    localparam int REP_W  = 16;
    localparam int OUTC_W = 7;

    typedef enum logic [2:0] {
        OP_RECORD = 3'd0,
        OP_BACK   = 3'd1,
        OP_FWD    = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_RAW    = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]              operation;
        logic signed [KEY_W-1:0] file_key;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [REP_W-1:0]        repeat_count;
    } t_req;

    typedef struct packed {
        logic                    moved;
        logic signed [KEY_W-1:0] dest_file_key;
        logic [ROW_W-1:0]        dest_row;
        logic [COL_W-1:0]        dest_col;
        logic [OUTC_W-1:0]       entry_count;
        logic [OUTC_W-1:0]       cursor_pos;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_DEST_RD,
        S_DEST_WAIT,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/jhl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhl_req_if / jhl_rsp_if
// Valid/ready channels carrying requests and responses of the history list.
// ----------------------------------------------------------------------------
interface jhl_req_if;
    logic          valid;
    logic          ready;
    jhl_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface jhl_rsp_if;
    logic          valid;
    logic          ready;
    jhl_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/jump_history_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_history_list
// Bounded navigation history with cursor, duplicate removal and eviction.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per transaction (record, step back, step
//   forward, clear, raw append); o_rsp returns exactly one response per
//   request, in order. Entries live in one single-port-read, single-port-write
//   synchronous memory of HISTORY_DEPTH words.
//   Clear, unknown operations and steps that cannot move go straight to the
//   output; a step that moves first reads its destination entry, a step back
//   from the tip first appends the current position. A record scans stored
//   entries one at a time, and removing a duplicate or evicting the oldest
//   entry moves every later entry down one place, each through the memory's
//   one read port.
//   One request is in work at a time; i_req.ready is high in the idle state.
//   A new request is taken while the previous response still waits in the
//   output register; a stalled o_rsp holds its transaction and blocks the
//   next response until it is taken.
//   Reset empties the list and clears the cursor; memory contents are left
//   as they are and are never read before written.
// ----------------------------------------------------------------------------
module jump_history_list #(
    parameter int HISTORY_DEPTH = jhl_pkg::JHL_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    jhl_req_if.sink   i_req,
    jhl_rsp_if.source o_rsp
);
    import jhl_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = ((CW > REP_W) ? CW : REP_W) + 1;

    // State and control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_evict, n_evict;
    logic          r_moved, n_moved;
    logic          r_ovalid, n_ovalid;

    // Request and response payload
    t_op              r_op, n_op;
    t_entry           r_ent, n_ent;
    logic [REP_W-1:0] r_reps, n_reps;
    t_rsp             r_rsp, n_rsp;

    // Memory
    t_entry        mem [HISTORY_DEPTH];
    t_entry        r_rd_data;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        wr_data;

    logic [SW-1:0] s_count, s_cursor, s_idx1, s_reps, s_cnt1;
    logic          accept;

    assign accept   = i_req.valid && i_req.ready;
    assign s_count  = SW'(r_count);
    assign s_cursor = SW'(r_cursor);
    assign s_idx1   = SW'(r_idx) + SW'(1);
    assign s_reps   = SW'(r_reps);
    assign s_cnt1   = SW'(r_count) + SW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority case (i_req.payload.operation)
                        OP_RECORD: n_state = (r_cursor == '0) ? S_APPEND : S_SRCH_RD;
                        OP_BACK: begin
                            if (r_cursor == r_count) begin
                                if (r_count == '0) begin
                                    n_state = S_OUT;
                                end else if (s_count >= SW'(HISTORY_DEPTH)) begin
                                    n_state = S_SHIFT_RD;
                                end else begin
                                    n_state = S_APPEND;
                                end
                            end else if (r_cursor != '0) begin
                                n_state = S_DEST_RD;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        OP_FWD: n_state = (s_cursor + SW'(1) < s_count) ? S_DEST_RD : S_OUT;
                        OP_RAW: n_state = (s_count >= SW'(HISTORY_DEPTH)) ? S_SHIFT_RD
                                                                           : S_APPEND;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (r_idx < r_count) begin
                    n_state = S_SRCH_CMP;
                end else if (s_count >= SW'(HISTORY_DEPTH)) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_SRCH_CMP: begin
                if (r_rd_data.key == r_ent.key && r_rd_data.row == r_ent.row) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:  n_state = (s_idx1 < s_count) ? S_SHIFT_WR : S_APPEND;
            S_SHIFT_WR:  n_state = S_SHIFT_RD;
            S_APPEND:    n_state = (r_op == OP_BACK) ? S_DEST_RD : S_OUT;
            S_DEST_RD:   n_state = S_DEST_WAIT;
            S_DEST_WAIT: n_state = S_OUT;
            S_OUT:       n_state = (!r_ovalid || o_rsp.ready) ? S_IDLE : S_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_evict  = r_evict;
        n_moved  = r_moved;
        n_op     = r_op;
        n_ent    = r_ent;
        n_reps   = r_reps;
        n_rsp    = r_rsp;
        n_ovalid = r_ovalid;
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_idx[AW-1:0];
        wr_data  = r_rd_data;

        // drop the response once taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = t_op'(i_req.payload.operation);
                    n_ent.key = i_req.payload.file_key;
                    n_ent.row = i_req.payload.row;
                    n_ent.col = i_req.payload.col;
                    n_reps    = (i_req.payload.repeat_count == '0) ? REP_W'(1)
                                                                  : i_req.payload.repeat_count;
                    n_moved   = 1'b0;
                    n_idx     = '0;
                    n_evict   = 1'b1;
                    priority case (i_req.payload.operation)
                        OP_RECORD: n_count = r_cursor;
                        OP_BACK: begin
                            if (r_cursor != r_count && r_cursor != '0) begin
                                n_moved  = 1'b1;
                                n_cursor = (SW'(r_cursor) > SW'(n_reps))
                                         ? CW'(SW'(r_cursor) - SW'(n_reps)) : '0;
                            end
                        end
                        OP_FWD: begin
                            if (s_cursor + SW'(1) < s_count) begin
                                n_moved  = 1'b1;
                                n_cursor = (s_cursor + SW'(n_reps) < s_count)
                                         ? CW'(s_cursor + SW'(n_reps))
                                         : CW'(s_count - SW'(1));
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (r_idx < r_count) begin
                    rd_en = 1'b1;
                end else begin
                    n_idx = '0;
                end
            end
            S_SRCH_CMP: begin
                if (r_rd_data.key == r_ent.key && r_rd_data.row == r_ent.row) begin
                    n_evict = 1'b0;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SHIFT_RD: begin
                if (s_idx1 < s_count) begin
                    rd_en   = 1'b1;
                    rd_addr = s_idx1[AW-1:0];
                end else begin
                    // shift done: one entry fewer, a record keeps its cursor at the tip
                    n_count = r_count - CW'(1);
                    if ((r_evict || r_op == OP_RECORD) && r_cursor != '0) begin
                        n_cursor = r_cursor - CW'(1);
                    end
                end
            end
            S_SHIFT_WR: begin
                wr_en = 1'b1;
                n_idx = r_idx + CW'(1);
            end
            S_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                wr_data = r_ent;
                n_count = r_count + CW'(1);
                if (r_op == OP_RECORD) begin
                    n_cursor = r_count + CW'(1);
                end else if (r_op == OP_BACK) begin
                    n_moved  = 1'b1;
                    n_cursor = (s_cnt1 > s_reps) ? CW'(s_cnt1 - SW'(1) - s_reps) : '0;
                end
            end
            S_DEST_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_cursor[AW-1:0];
            end
            S_DEST_WAIT: ;
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid            = 1'b1;
                    n_rsp.moved         = r_moved;
                    n_rsp.dest_file_key = r_moved ? r_rd_data.key : '0;
                    n_rsp.dest_row      = r_moved ? r_rd_data.row : '0;
                    n_rsp.dest_col      = r_moved ? r_rd_data.col : '0;
                    n_rsp.entry_count   = OUTC_W'(r_count);
                    n_rsp.cursor_pos    = OUTC_W'(r_cursor);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_evict <= n_evict;
        r_moved <= n_moved;
        r_op    <= n_op;
        r_ent   <= n_ent;
        r_reps  <= n_reps;
        r_rsp   <= n_rsp;
    end

    // Entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    // Checks
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond entry count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_count) <= SW'(HISTORY_DEPTH))
        else $error("entry count beyond depth");

    a_no_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_rsp.moved) |-> (r_rsp.dest_row == '0 && r_rsp.dest_col == '0))
        else $error("destination not zero without move");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (SW'(r_count) < SW'(HISTORY_DEPTH)))
        else $error("append into full memory");

endmodule
